>>> hw/rtl/dsdl_pkg.sv
// ----------------------------------------------------------------------------
// dsdl_pkg
// Shared types and constants for the depth sorted draw list.
// ----------------------------------------------------------------------------
package dsdl_pkg;

    // Command codes carried on the opcode port.
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // Field widths of one primitive entry.
    localparam int DEPTH_W  = 16;
    localparam int COUNT_W  = 4;
    localparam int COLOUR_W = 8;
    localparam int SLOT_W   = 6;

    // Most entries emitted by one finish command, and the counter width for it.
    localparam int MAX_RESULTS = 64;
    localparam int EMIT_W      = 7;

    // Payload of one pool entry as held in the entry memory.
    typedef struct packed {
        logic signed [DEPTH_W-1:0] depth;
        logic [COUNT_W-1:0]        point_count;
        logic [COLOUR_W-1:0]       colour;
    } entry_t;

endpackage

>>> hw/rtl/dsdl_store.sv
// ----------------------------------------------------------------------------
// dsdl_store
// Pool storage: a link memory (next slot plus end bit) and an entry memory,
// both read at one shared address with registered data, one write port each.
// ----------------------------------------------------------------------------
module dsdl_store #(
    parameter int SLOTS = 64
) (
    input  logic                       clk,
    input  logic [$clog2(SLOTS)-1:0]   rd_addr,
    input  logic                       link_we,
    input  logic [$clog2(SLOTS)-1:0]   link_waddr,
    input  logic [$clog2(SLOTS):0]     link_wdata,
    input  logic                       data_we,
    input  logic [$clog2(SLOTS)-1:0]   data_waddr,
    input  dsdl_pkg::entry_t           data_wdata,
    output logic [$clog2(SLOTS):0]     rd_link,
    output dsdl_pkg::entry_t           rd_data
);

    localparam int IDX_W = $clog2(SLOTS);

    logic [IDX_W:0]   link_mem [SLOTS];
    dsdl_pkg::entry_t data_mem [SLOTS];

    // Link memory: one write, one read per cycle, read data registered.
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        rd_link <= link_mem[rd_addr];
    end

    // Entry memory: written once per insert that finds a free slot, read at the same address as links.
    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_waddr] <= data_wdata;
        end
        rd_data <= data_mem[rd_addr];
    end

endmodule

>>> hw/rtl/depth_sorted_draw_list.sv
// ----------------------------------------------------------------------------
// depth_sorted_draw_list
// Painter's algorithm draw list: a pool of primitives kept as a linked chain
// sorted far to near, emitted in that order on request.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken at a clock edge where start is high and busy is
//   low. Opcode start empties the pool. Opcode insert stores the primitive in
//   the next free slot and links it ahead of the first entry of strictly
//   smaller depth; it walks the chain one entry per cycle through the link
//   memory read port, holding busy until the new entry is linked. An insert
//   into an empty pool or into a full pool is done in the cycle it is taken
//   and never raises busy. Opcode finish walks the chain: the head entry is
//   read from the memory, then the result words are registered out one word
//   per cycle, out_valid high for exactly one cycle each, last high on the
//   final word. At most 64 words are emitted; an empty pool emits nothing.
//   The chain walk does one memory read per word. busy falls in the cycle of
//   the last result word. Results cannot be held off: the receiver must take
//   each word while out_valid is high. Reset empties the pool; the memories
//   are not cleared since a slot is always written before it is linked.
// ----------------------------------------------------------------------------
module depth_sorted_draw_list #(
    parameter int POOL_SLOTS = 64
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic [1:0]                               opcode,
    input  logic signed [dsdl_pkg::DEPTH_W-1:0]      depth,
    input  logic [dsdl_pkg::COUNT_W-1:0]             point_count,
    input  logic [dsdl_pkg::COLOUR_W-1:0]            colour,
    output logic                                     out_valid,
    output logic [dsdl_pkg::SLOT_W-1:0]              slot,
    output logic signed [dsdl_pkg::DEPTH_W-1:0]      out_depth,
    output logic [dsdl_pkg::COUNT_W-1:0]             out_point_count,
    output logic [dsdl_pkg::COLOUR_W-1:0]            out_colour,
    output logic                                     last
);

    localparam int IDX_W = $clog2(POOL_SLOTS);
    localparam int CNT_W = $clog2(POOL_SLOTS + 1);
    localparam int CMP_W = (CNT_W > dsdl_pkg::EMIT_W) ? CNT_W : dsdl_pkg::EMIT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_HEAD,
        ST_INS_WALK,
        ST_INS_FIX,
        ST_FIN
    } state_t;

    state_t                       state_reg, state_next;
    logic [IDX_W-1:0]             head_reg, head_next;
    logic [CNT_W-1:0]             used_reg, used_next;
    logic [IDX_W-1:0]             new_reg, new_next;
    logic [IDX_W-1:0]             cur_reg, cur_next;
    logic [IDX_W-1:0]             nx_reg, nx_next;
    logic signed [dsdl_pkg::DEPTH_W-1:0] ins_depth_reg, ins_depth_next;
    logic [dsdl_pkg::EMIT_W-1:0]  emit_cnt_reg, emit_cnt_next;
    logic [dsdl_pkg::EMIT_W-1:0]  lim_reg, lim_next;
    logic                         strobe_reg, strobe_next;
    logic                         last_reg, last_next;
    logic [dsdl_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    dsdl_pkg::entry_t             out_reg, out_next;

    logic [IDX_W-1:0]             rd_addr;
    logic                         link_we;
    logic [IDX_W-1:0]             link_waddr;
    logic [IDX_W:0]               link_wdata;
    logic                         data_we;
    dsdl_pkg::entry_t             data_wdata;
    logic [IDX_W:0]               rd_link;
    dsdl_pkg::entry_t             rd_data;

    logic                         accept;
    logic                         pool_full;
    logic                         lnk_end;
    logic [IDX_W-1:0]             lnk_idx;
    logic                         farther;
    logic [CMP_W-1:0]             used_ext;
    logic [IDX_W+dsdl_pkg::SLOT_W-1:0] slot_ext;
    logic                         final_word;

    dsdl_store #(
        .SLOTS (POOL_SLOTS)
    ) u_store (
        .clk        (clk),
        .rd_addr    (rd_addr),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .data_we    (data_we),
        .data_waddr (used_reg[IDX_W-1:0]),
        .data_wdata (data_wdata),
        .rd_link    (rd_link),
        .rd_data    (rd_data)
    );

    // Handshake and decoded read data.
    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign pool_full  = (used_reg == CNT_W'(POOL_SLOTS));
    assign lnk_end    = rd_link[IDX_W];
    assign lnk_idx    = rd_link[IDX_W-1:0];
    assign farther    = (ins_depth_reg > rd_data.depth);
    assign used_ext   = CMP_W'(used_reg);
    assign slot_ext   = {{dsdl_pkg::SLOT_W{1'b0}}, nx_reg};
    assign final_word = lnk_end || ((emit_cnt_reg + 1'b1) == lim_reg);

    assign data_wdata.depth       = depth;
    assign data_wdata.point_count = point_count;
    assign data_wdata.colour      = colour;

    // Sequencer: command decode, insert walk and finish walk.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        used_next      = used_reg;
        new_next       = new_reg;
        cur_next       = cur_reg;
        nx_next        = nx_reg;
        ins_depth_next = ins_depth_reg;
        emit_cnt_next  = emit_cnt_reg;
        lim_next       = lim_reg;
        strobe_next    = 1'b0;
        last_next      = 1'b0;
        slot_next      = slot_reg;
        out_next       = out_reg;
        rd_addr        = nx_reg;
        link_we        = 1'b0;
        link_waddr     = new_reg;
        link_wdata     = {1'b0, new_reg};
        data_we        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        dsdl_pkg::OP_START:
                        begin
                            head_next = '0;
                            used_next = '0;
                        end
                        dsdl_pkg::OP_INSERT:
                        begin
                            if (!pool_full)
                            begin
                                // Store the entry and mark it as chain end.
                                data_we        = 1'b1;
                                link_we        = 1'b1;
                                link_waddr     = used_reg[IDX_W-1:0];
                                link_wdata     = {1'b1, {IDX_W{1'b0}}};
                                used_next      = used_reg + 1'b1;
                                new_next       = used_reg[IDX_W-1:0];
                                ins_depth_next = depth;
                                if (used_reg == '0)
                                begin
                                    head_next = '0;
                                end
                                else
                                begin
                                    nx_next    = head_reg;
                                    rd_addr    = head_reg;
                                    state_next = ST_INS_HEAD;
                                end
                            end
                        end
                        dsdl_pkg::OP_FINISH:
                        begin
                            if (used_reg != '0)
                            begin
                                nx_next       = head_reg;
                                rd_addr       = head_reg;
                                emit_cnt_next = '0;
                                if (used_ext >= CMP_W'(dsdl_pkg::MAX_RESULTS))
                                begin
                                    lim_next = dsdl_pkg::EMIT_W'(dsdl_pkg::MAX_RESULTS);
                                end
                                else
                                begin
                                    lim_next = used_ext[dsdl_pkg::EMIT_W-1:0];
                                end
                                state_next = ST_FIN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_INS_HEAD, ST_INS_WALK:
            begin
                if (farther && state_reg == ST_INS_HEAD)
                begin
                    // New entry becomes the head of the chain.
                    link_we    = 1'b1;
                    link_waddr = new_reg;
                    link_wdata = {1'b0, nx_reg};
                    head_next  = new_reg;
                    state_next = ST_IDLE;
                end
                else if (farther)
                begin
                    // Splice in after the previous entry; its successor follows.
                    link_we    = 1'b1;
                    link_waddr = cur_reg;
                    link_wdata = {1'b0, new_reg};
                    state_next = ST_INS_FIX;
                end
                else
                begin
                    cur_next = nx_reg;
                    if (lnk_end)
                    begin
                        // Append at the tail.
                        link_we    = 1'b1;
                        link_waddr = nx_reg;
                        link_wdata = {1'b0, new_reg};
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        nx_next    = lnk_idx;
                        rd_addr    = lnk_idx;
                        state_next = ST_INS_WALK;
                    end
                end
            end

            ST_INS_FIX:
            begin
                link_we    = 1'b1;
                link_waddr = new_reg;
                link_wdata = {1'b0, nx_reg};
                state_next = ST_IDLE;
            end

            ST_FIN:
            begin
                // One word per cycle; the next address comes from this read.
                strobe_next   = 1'b1;
                last_next     = final_word;
                slot_next     = slot_ext[dsdl_pkg::SLOT_W-1:0];
                out_next      = rd_data;
                emit_cnt_next = emit_cnt_reg + 1'b1;
                if (final_word)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    nx_next = lnk_idx;
                    rd_addr = lnk_idx;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            used_reg     <= '0;
            emit_cnt_reg <= '0;
            lim_reg      <= '0;
            strobe_reg   <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            used_reg     <= used_next;
            emit_cnt_reg <= emit_cnt_next;
            lim_reg      <= lim_next;
            strobe_reg   <= strobe_next;
            last_reg     <= last_next;
        end
    end

    // Walk pointers and result payload.
    always_ff @(posedge clk)
    begin
        new_reg       <= new_next;
        cur_reg       <= cur_next;
        nx_reg        <= nx_next;
        ins_depth_reg <= ins_depth_next;
        slot_reg      <= slot_next;
        out_reg       <= out_next;
    end

    assign out_valid       = strobe_reg;
    assign last            = last_reg;
    assign slot            = slot_reg;
    assign out_depth       = out_reg.depth;
    assign out_point_count = out_reg.point_count;
    assign out_colour      = out_reg.colour;

endmodule

>>> hw/rtl/dsdl_checker.sv
// ----------------------------------------------------------------------------
// dsdl_checker
// Port-level checks on the draw list result stream, bound to the top level.
// ----------------------------------------------------------------------------
module dsdl_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [1:0]                          opcode,
    input logic                                out_valid,
    input logic                                last
);

    // Results only come out of a command that held busy.
    a_valid_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(busy))
        else $error("result word without a command in progress");

    // The last marker only travels with a result word.
    a_last_with_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> out_valid)
        else $error("last marker outside a result word");

    // A list streams without gaps until its last word.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |=> out_valid)
        else $error("gap inside the emitted list");

    // The list ends with its last word, and busy is down by then.
    a_end_of_list: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (!busy ##1 !out_valid))
        else $error("list did not end after the last word");

    // A start command on an idle block leaves busy low.
    a_start_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == dsdl_pkg::OP_START) |=> !busy)
        else $error("start command held busy");

endmodule

bind depth_sorted_draw_list dsdl_checker u_dsdl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .out_valid (out_valid),
    .last      (last)
);

>>> tb/depth_sorted_draw_list_tb.sv
// ----------------------------------------------------------------------------
// depth_sorted_draw_list_tb
// Self-checking bench for the depth sorted draw list. A short table of
// commands covers the empty pool, depth extremes, equal depths, head, middle
// and tail links, repeated finish and the unused opcode. Random sessions
// follow: start, a run of inserts (the first overfills the pool), a finish;
// each finish word is checked by a sorted chain model or a typed expectation.
// ----------------------------------------------------------------------------
module depth_sorted_draw_list_tb;

    localparam int          POOL          = 64;
    localparam int          RANDOM_WORDS  = 130;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = 80;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;

    // One emitted draw list word.
    typedef struct packed {
        logic [dsdl_pkg::SLOT_W-1:0]         slot;
        logic signed [dsdl_pkg::DEPTH_W-1:0] depth;
        logic [dsdl_pkg::COUNT_W-1:0]        point_count;
        logic [dsdl_pkg::COLOUR_W-1:0]       colour;
        logic                                last;
    } draw_word_t;

    // One command word, with an optional hand-written expectation.
    typedef struct packed {
        logic [1:0]                          op;
        logic signed [dsdl_pkg::DEPTH_W-1:0] depth;
        logic [dsdl_pkg::COUNT_W-1:0]        point_count;
        logic [dsdl_pkg::COLOUR_W-1:0]       colour;
        logic                                typed;
        logic                                has_word;
        draw_word_t                          word;
    } cmd_row_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  start;
    logic                                  busy;
    logic [1:0]                            opcode;
    logic signed [dsdl_pkg::DEPTH_W-1:0]   depth;
    logic [dsdl_pkg::COUNT_W-1:0]          point_count;
    logic [dsdl_pkg::COLOUR_W-1:0]         colour;
    logic                                  out_valid;
    logic [dsdl_pkg::SLOT_W-1:0]           slot;
    logic signed [dsdl_pkg::DEPTH_W-1:0]   out_depth;
    logic [dsdl_pkg::COUNT_W-1:0]          out_point_count;
    logic [dsdl_pkg::COLOUR_W-1:0]         out_colour;
    logic                                  last;

    // Local copy of the pool and its sorted chain.
    logic signed [dsdl_pkg::DEPTH_W-1:0]   pool_depth [POOL];
    logic [dsdl_pkg::COUNT_W-1:0]          pool_count [POOL];
    logic [dsdl_pkg::COLOUR_W-1:0]         pool_colour [POOL];
    int                                    pool_next [POOL];
    bit                                    pool_tail [POOL];
    int                                    chain_head;
    int                                    pool_used;

    draw_word_t                            fresh_words [$];
    draw_word_t                            pending_words [$];
    cmd_row_t                              directed_rows [$];

    // Expectation handed from the driver to the monitor with each word.
    bit                                    typed_row;
    bit                                    typed_has;
    draw_word_t                            typed_word;

    int                                    mismatches;
    int                                    words_checked;
    int                                    inserts_sent;
    int                                    finishes_sent;
    int                                    dropped_inserts;
    int                                    random_words;
    int                                    burst_left;
    int                                    cycle_count;
    logic signed [dsdl_pkg::DEPTH_W-1:0]   prev_depth;

    depth_sorted_draw_list u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .depth           (depth),
        .point_count     (point_count),
        .colour          (colour),
        .out_valid       (out_valid),
        .slot            (slot),
        .out_depth       (out_depth),
        .out_point_count (out_point_count),
        .out_colour      (out_colour),
        .last            (last)
    );

    // Clock with a period of two time units.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic draw_word_t make_word(int s,
                                             logic signed [dsdl_pkg::DEPTH_W-1:0] d,
                                             logic [dsdl_pkg::COUNT_W-1:0] pc,
                                             logic [dsdl_pkg::COLOUR_W-1:0] col,
                                             logic fin);
        draw_word_t w;
        w.slot        = dsdl_pkg::SLOT_W'(s);
        w.depth       = d;
        w.point_count = pc;
        w.colour      = col;
        w.last        = fin;
        return w;
    endfunction

    function automatic cmd_row_t plain_row(logic [1:0] op,
                                           logic signed [dsdl_pkg::DEPTH_W-1:0] d,
                                           logic [dsdl_pkg::COUNT_W-1:0] pc,
                                           logic [dsdl_pkg::COLOUR_W-1:0] col);
        cmd_row_t r;
        r.op          = op;
        r.depth       = d;
        r.point_count = pc;
        r.colour      = col;
        r.typed       = 1'b0;
        r.has_word    = 1'b0;
        r.word        = '0;
        return r;
    endfunction

    // Store a primitive in the next free slot and link it in ahead of the
    // first entry that is strictly nearer, so equal depths keep arrival order.
    function automatic void link_primitive(logic signed [dsdl_pkg::DEPTH_W-1:0] d,
                                           logic [dsdl_pkg::COUNT_W-1:0] pc,
                                           logic [dsdl_pkg::COLOUR_W-1:0] col);
        int  fresh;
        int  cur;
        int  nxt;
        bit  placed;
        if (pool_used >= POOL)
        begin
            dropped_inserts++;
            return;
        end
        fresh             = pool_used;
        pool_used         = pool_used + 1;
        pool_depth[fresh] = d;
        pool_count[fresh] = pc;
        pool_colour[fresh] = col;
        pool_tail[fresh]  = 1'b1;
        if (fresh == 0)
        begin
            chain_head = 0;
            return;
        end
        if (d > pool_depth[chain_head])
        begin
            pool_next[fresh] = chain_head;
            pool_tail[fresh] = 1'b0;
            chain_head       = fresh;
            return;
        end
        cur    = chain_head;
        placed = 1'b0;
        while (!placed && !pool_tail[cur])
        begin
            nxt = pool_next[cur];
            if (d > pool_depth[nxt])
            begin
                pool_next[cur]   = fresh;
                pool_tail[cur]   = 1'b0;
                pool_next[fresh] = nxt;
                pool_tail[fresh] = 1'b0;
                placed           = 1'b1;
            end
            else
                cur = nxt;
        end
        // Nearest so far: it goes on the end of the chain.
        if (!placed)
        begin
            pool_next[cur] = fresh;
            pool_tail[cur] = 1'b0;
        end
    endfunction

    // Walk the chain far to near and queue one word per entry.
    function automatic void emit_chain();
        int          cur;
        int          n;
        draw_word_t  w;
        if (pool_used == 0)
            return;
        cur = chain_head;
        n   = 0;
        do
        begin
            n++;
            w = make_word(cur, pool_depth[cur], pool_count[cur], pool_colour[cur],
                          pool_tail[cur] || n == dsdl_pkg::MAX_RESULTS ||
                          n == pool_used);
            fresh_words.push_back(w);
            cur = pool_next[cur];
        end
        while (!w.last);
    endfunction

    function automatic void apply_command(logic [1:0] op,
                                          logic signed [dsdl_pkg::DEPTH_W-1:0] d,
                                          logic [dsdl_pkg::COUNT_W-1:0] pc,
                                          logic [dsdl_pkg::COLOUR_W-1:0] col);
        case (op)
            dsdl_pkg::OP_START:
            begin
                chain_head = 0;
                pool_used  = 0;
            end
            dsdl_pkg::OP_INSERT: link_primitive(d, pc, col);
            dsdl_pkg::OP_FINISH: emit_chain();
            default:   ;
        endcase
    endfunction

    // Monitor: check each result word, then predict for a command taken at
    // this edge. Results of a new command only come at a later edge.
    always @(posedge clk)
    begin
        draw_word_t got;
        draw_word_t want;
        if (rst_n)
        begin
            if (out_valid)
            begin
                got = make_word(slot, out_depth, out_point_count, out_colour, last);
                words_checked++;
                if (pending_words.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected word: slot %0d depth %0d cnt %0d col %0d last %0b",
                                 got.slot, got.depth, got.point_count, got.colour,
                                 got.last);
                    mismatches++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (got.slot !== want.slot || got.depth !== want.depth ||
                        got.point_count !== want.point_count ||
                        got.colour !== want.colour || got.last !== want.last)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("expected slot %0d depth %0d cnt %0d col %0d last %0b",
                                     want.slot, want.depth, want.point_count, want.colour,
                                     want.last);
                            $display("actual   slot %0d depth %0d cnt %0d col %0d last %0b",
                                     got.slot, got.depth, got.point_count, got.colour,
                                     got.last);
                        end
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                apply_command(opcode, depth, point_count, colour);
                if (typed_row)
                begin
                    fresh_words.delete();
                    if (typed_has)
                        pending_words.push_back(typed_word);
                end
                else
                begin
                    while (fresh_words.size() != 0)
                        pending_words.push_back(fresh_words.pop_front());
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("depth_sorted_draw_list: mismatch");
            $finish;
        end
    end

    // Present one command word, after an idle gap when the burst is used up,
    // and hold it until the block takes it.
    task automatic send_word(input cmd_row_t row);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 9);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        typed_row   = row.typed;
        typed_has   = row.has_word;
        typed_word  = row.word;
        start       <= 1'b1;
        opcode      <= row.op;
        depth       <= row.depth;
        point_count <= row.point_count;
        colour      <= row.colour;
        if (row.op == dsdl_pkg::OP_INSERT)
            inserts_sent++;
        if (row.op == dsdl_pkg::OP_FINISH)
            finishes_sent++;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop sending until every expected word has come back.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(logic [1:0] op, logic signed [dsdl_pkg::DEPTH_W-1:0] d,
                           logic [dsdl_pkg::COUNT_W-1:0] pc,
                           logic [dsdl_pkg::COLOUR_W-1:0] col,
                           logic typed, logic has_word, draw_word_t w);
        cmd_row_t r;
        r          = plain_row(op, d, pc, col);
        r.typed    = typed;
        r.has_word = has_word;
        r.word     = w;
        directed_rows.push_back(r);
    endtask

    function automatic logic signed [dsdl_pkg::DEPTH_W-1:0] pick_depth();
        logic signed [dsdl_pkg::DEPTH_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = dsdl_pkg::DEPTH_W'($urandom_range(0, 8) - 4);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = 16'sh8000;
                    1: v = 16'sh7fff;
                    2: v = -16'sd1;
                    default: v = 16'sd0;
                endcase
            end
            2: v = prev_depth;
            default: v = dsdl_pkg::DEPTH_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic cmd_row_t random_insert();
        cmd_row_t r;
        r = plain_row(dsdl_pkg::OP_INSERT, pick_depth(),
                      dsdl_pkg::COUNT_W'($urandom_range(0, 15)),
                      dsdl_pkg::COLOUR_W'($urandom_range(0, 255)));
        prev_depth = r.depth;
        return r;
    endfunction

    initial
    begin
        int n_ins;
        int session;
        start           = 1'b0;
        opcode          = dsdl_pkg::OP_START;
        depth           = '0;
        point_count     = '0;
        colour          = '0;
        rst_n           = 1'b0;
        typed_row       = 1'b0;
        typed_has       = 1'b0;
        typed_word      = '0;
        chain_head      = 0;
        pool_used       = 0;
        mismatches      = 0;
        words_checked   = 0;
        inserts_sent    = 0;
        finishes_sent   = 0;
        dropped_inserts = 0;
        random_words    = 0;
        burst_left      = 0;
        cycle_count     = 0;
        prev_depth      = '0;

        // Directed table. Rows with a typed expectation are read straight
        // off the behavior; the rest go through the chain model.
        add_row(dsdl_pkg::OP_FINISH, 16'sd0, 4'd0, 8'd0, 1'b1, 1'b0, '0);
        add_row(dsdl_pkg::OP_INSERT, 16'sh7fff, 4'd15, 8'd255, 1'b1, 1'b0, '0);
        add_row(dsdl_pkg::OP_FINISH, 16'sd0, 4'd0, 8'd0, 1'b1, 1'b1,
                make_word(0, 16'sh7fff, 4'd15, 8'd255, 1'b1));
        add_row(dsdl_pkg::OP_FINISH, 16'sd0, 4'd0, 8'd0, 1'b1, 1'b1,
                make_word(0, 16'sh7fff, 4'd15, 8'd255, 1'b1));
        add_row(dsdl_pkg::OP_START, 16'sh7fff, 4'd15, 8'd255, 1'b1, 1'b0, '0);
        add_row(dsdl_pkg::OP_FINISH, 16'sd0, 4'd0, 8'd0, 1'b1, 1'b0, '0);
        add_row(dsdl_pkg::OP_INSERT, 16'sh8000, 4'd0, 8'd0, 1'b1, 1'b0, '0);
        add_row(dsdl_pkg::OP_FINISH, 16'sd0, 4'd0, 8'd0, 1'b1, 1'b1,
                make_word(0, 16'sh8000, 4'd0, 8'd0, 1'b1));
        add_row(OP_UNUSED, 16'sh7fff, 4'd15, 8'd255, 1'b1, 1'b0, '0);
        add_row(dsdl_pkg::OP_INSERT, 16'sd0, 4'd2, 8'h55, 1'b0, 1'b0, '0);
        add_row(dsdl_pkg::OP_INSERT, 16'sd0, 4'd3, 8'haa, 1'b0, 1'b0, '0);
        add_row(dsdl_pkg::OP_INSERT, 16'sh7fff, 4'd8, 8'd1, 1'b0, 1'b0, '0);
        add_row(dsdl_pkg::OP_INSERT, 16'sh8000, 4'd5, 8'd2, 1'b0, 1'b0, '0);
        add_row(dsdl_pkg::OP_INSERT, 16'sd100, 4'd4, 8'd3, 1'b0, 1'b0, '0);
        add_row(dsdl_pkg::OP_INSERT, -16'sd1, 4'd7, 8'd4, 1'b0, 1'b0, '0);
        add_row(OP_UNUSED, 16'sh5a5a, 4'd9, 8'h3c, 1'b0, 1'b0, '0);
        add_row(dsdl_pkg::OP_FINISH, 16'sd0, 4'd0, 8'd0, 1'b0, 1'b0, '0);
        add_row(dsdl_pkg::OP_START, 16'sd0, 4'd0, 8'd0, 1'b0, 1'b0, '0);
        add_row(dsdl_pkg::OP_INSERT, 16'sd5, 4'd1, 8'h0f, 1'b0, 1'b0, '0);
        add_row(dsdl_pkg::OP_FINISH, 16'sd0, 4'd0, 8'd0, 1'b0, 1'b0, '0);
        add_row(dsdl_pkg::OP_INSERT, -16'sd5, 4'd6, 8'hf0, 1'b0, 1'b0, '0);
        add_row(dsdl_pkg::OP_FINISH, 16'sd0, 4'd0, 8'd0, 1'b0, 1'b0, '0);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i]);
        drain_results();

        // Random sessions: mostly start, inserts and finish, with stray
        // unused opcodes, early finishes and an occasional skipped start.
        session = 0;
        while (random_words < RANDOM_WORDS)
        begin
            if (session == 0 || $urandom_range(0, 7) != 0)
            begin
                send_word(plain_row(dsdl_pkg::OP_START, dsdl_pkg::DEPTH_W'($urandom),
                                    dsdl_pkg::COUNT_W'($urandom_range(0, 15)),
                                    dsdl_pkg::COLOUR_W'($urandom_range(0, 255))));
                random_words++;
            end
            if (session == 0)
                n_ins = POOL + 4;
            else
            begin
                case ($urandom_range(0, 9))
                    0: n_ins = $urandom_range(20, POOL);
                    1: n_ins = 0;
                    default: n_ins = $urandom_range(1, 10);
                endcase
            end
            repeat (n_ins)
            begin
                send_word(random_insert());
                random_words++;
                case ($urandom_range(0, 15))
                    0: send_word(plain_row(OP_UNUSED, dsdl_pkg::DEPTH_W'($urandom),
                                           dsdl_pkg::COUNT_W'($urandom_range(0, 15)),
                                           dsdl_pkg::COLOUR_W'($urandom_range(0, 255))));
                    1:
                    begin
                        send_word(plain_row(dsdl_pkg::OP_FINISH, '0, '0, '0));
                        random_words++;
                    end
                    default: ;
                endcase
            end
            send_word(plain_row(dsdl_pkg::OP_FINISH, dsdl_pkg::DEPTH_W'($urandom),
                                dsdl_pkg::COUNT_W'($urandom_range(0, 15)),
                                dsdl_pkg::COLOUR_W'($urandom_range(0, 255))));
            random_words++;
            if ($urandom_range(0, 3) == 0)
            begin
                send_word(plain_row(dsdl_pkg::OP_FINISH, '0, '0, '0));
                random_words++;
            end
            if ($urandom_range(0, 4) == 0)
                drain_results();
            session++;
        end

        // Wait for the last words, then give a trailing insert time to finish
        // and any stray word time to show up.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d inserts (%0d dropped on a full pool) and %0d finishes,",
                 inserts_sent, dropped_inserts, finishes_sent);
        $display("checking %0d sorted result words in %0d sessions.", words_checked, session);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("depth_sorted_draw_list: match");
        else
            $display("depth_sorted_draw_list: mismatch");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/dsdl_pkg.sv
hw/rtl/dsdl_store.sv
hw/rtl/depth_sorted_draw_list.sv
hw/rtl/dsdl_checker.sv
tb/depth_sorted_draw_list_tb.sv
